// ===== design/kth_permutation_unrank_macros.svh =====
// Assertion macros shared by the permutation unrank block.
// Used by kth_permutation_unrank.sv; expects clk and rst in scope.
`ifndef KTH_PERMUTATION_UNRANK_MACROS_SVH
`define KTH_PERMUTATION_UNRANK_MACROS_SVH

// Same-cycle implication, held off during reset
`define KPU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset
`define KPU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/kpu_pkg.sv =====
// Package for the permutation unrank block: word types, control structs,
// field widths and the factorial table. No dependencies.
`default_nettype none

package kpu_pkg;

  localparam int SIZE_W  = 4;
  localparam int RANK_W  = 19;
  localparam int DIGIT_W = 4;
  localparam int FACT_W  = 29;

  typedef struct packed {
    logic [SIZE_W-1:0] size_n;
    logic [RANK_W-1:0] rank_k;
  } in_word_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               last;
    logic               bad_request;
  } out_word_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic load;
    logic step;
    logic emit;
    logic emit_bad;
  } kpu_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic bad;
    logic div_done;
    logic left_one;
    logic out_free;
  } kpu_sts_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_EMIT,
    ST_BAD
  } kpu_state_t;

  // Factorial table; sizes above twelve saturate
  function automatic logic [FACT_W-1:0] fact_of(input logic [SIZE_W-1:0] m);
    logic [FACT_W-1:0] f;
    unique case (m)
      4'd0:    f = FACT_W'(1);
      4'd1:    f = FACT_W'(1);
      4'd2:    f = FACT_W'(2);
      4'd3:    f = FACT_W'(6);
      4'd4:    f = FACT_W'(24);
      4'd5:    f = FACT_W'(120);
      4'd6:    f = FACT_W'(720);
      4'd7:    f = FACT_W'(5040);
      4'd8:    f = FACT_W'(40320);
      4'd9:    f = FACT_W'(362880);
      4'd10:   f = FACT_W'(3628800);
      4'd11:   f = FACT_W'(39916800);
      4'd12:   f = FACT_W'(479001600);
      default: f = '1;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== design/kpu_datapath.sv =====
// Datapath of the permutation unrank block: request register, restoring
// divider by a factorial, value pool with removal, output register. Uses kpu_pkg.
`default_nettype none

module kpu_datapath #(
  parameter int MAX_N = 9
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire kpu_pkg::kpu_cmd_t cmd,
  output kpu_pkg::kpu_sts_t      sts,
  input  wire kpu_pkg::in_word_t in_data,
  output kpu_pkg::out_word_t     out_data,
  output logic                   out_valid,
  input  wire logic              out_ready
);

  localparam int LW = $clog2(MAX_N + 1);
  localparam int QW = $clog2(MAX_N);
  localparam int CW = (QW > 1) ? $clog2(QW) : 1;
  localparam int TW = kpu_pkg::FACT_W + QW;

  kpu_pkg::in_word_t              req;
  logic [kpu_pkg::DIGIT_W-1:0]    pool [MAX_N];
  logic [kpu_pkg::RANK_W-1:0]     rank;
  logic [LW-1:0]                  left;
  logic [QW-1:0]                  quo;
  logic [CW-1:0]                  cnt;

  logic [kpu_pkg::FACT_W-1:0]     fact_n;
  logic [kpu_pkg::FACT_W-1:0]     fact_left;
  logic [TW-1:0]                  trial;
  logic                           fits;
  logic [QW-1:0]                  idx;
  logic [kpu_pkg::DIGIT_W-1:0]    digit_sel;

  // Status to the controller: validity of the held request, divider and output state
  always_comb begin
    fact_n       = kpu_pkg::fact_of(req.size_n);
    sts.bad      = (req.size_n == '0) ||
                   (req.size_n > kpu_pkg::SIZE_W'(MAX_N)) ||
                   (req.rank_k == '0) ||
                   (kpu_pkg::FACT_W'(req.rank_k) > fact_n);
    sts.div_done = (cnt == '0);
    sts.left_one = (left == LW'(1));
    sts.out_free = !out_valid || out_ready;
  end

  // One quotient bit per step against (left-1)! scaled by the bit weight
  always_comb begin
    fact_left = kpu_pkg::fact_of(kpu_pkg::SIZE_W'(left - 1'b1));
    trial     = TW'(fact_left) << cnt;
    fits      = (TW'(rank) >= trial);
  end

  // Clamp the pool index to the last remaining value
  always_comb begin
    if (LW'(quo) >= left) begin
      idx = QW'(left - 1'b1);
    end else begin
      idx = quo;
    end
    digit_sel = pool[idx];
  end

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= in_data;
    end
  end

  // Load, divide and advance the rank, quotient and remaining count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rank <= kpu_pkg::RANK_W'(req.rank_k - 1'b1);
      left <= LW'(req.size_n);
      quo  <= '0;
      cnt  <= CW'(QW - 1);
    end else if (cmd.step) begin
      if (fits) begin
        rank     <= rank - kpu_pkg::RANK_W'(trial);
        quo[cnt] <= 1'b1;
      end
      if (cnt != '0) begin
        cnt <= cnt - 1'b1;
      end
    end else if (cmd.emit) begin
      left <= left - 1'b1;
      quo  <= '0;
      cnt  <= CW'(QW - 1);
    end
  end

  // Fill the pool with 1..MAX_N, drop the chosen value on emit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < MAX_N; i++) begin
        pool[i] <= kpu_pkg::DIGIT_W'(i + 1);
      end
    end else if (cmd.emit) begin
      for (int i = 0; i < MAX_N - 1; i++) begin
        if (i >= int'(idx)) begin
          pool[i] <= pool[i + 1];
        end
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.digit       <= digit_sel;
      out_data.last        <= sts.left_one;
      out_data.bad_request <= 1'b0;
    end else if (cmd.emit_bad) begin
      out_data.digit       <= '0;
      out_data.last        <= 1'b1;
      out_data.bad_request <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_bad) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== design/kpu_ctrl.sv =====
// Controller of the permutation unrank block: sequences check, division
// steps and digit or flagged-word emission. Uses kpu_pkg for state, command and status types.
`default_nettype none

module kpu_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire kpu_pkg::kpu_sts_t sts,
  output kpu_pkg::kpu_cmd_t      cmd
);

  kpu_pkg::kpu_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kpu_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      kpu_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = kpu_pkg::ST_CHECK;
        end
      end
      kpu_pkg::ST_CHECK: begin
        if (sts.bad) begin
          state_next = kpu_pkg::ST_BAD;
        end else begin
          cmd.load   = 1'b1;
          state_next = kpu_pkg::ST_DIV;
        end
      end
      kpu_pkg::ST_DIV: begin
        cmd.step = 1'b1;
        if (sts.div_done) begin
          state_next = kpu_pkg::ST_EMIT;
        end
      end
      kpu_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = sts.left_one ? kpu_pkg::ST_IDLE : kpu_pkg::ST_DIV;
        end
      end
      kpu_pkg::ST_BAD: begin
        if (sts.out_free) begin
          cmd.emit_bad = 1'b1;
          state_next   = kpu_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = kpu_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/kth_permutation_unrank.sv =====
// Sequence: a check state, then per digit the bit-serial factorial divider steps and an
//   emit state; a flagged request gives its single word from the bad state after the check.
// A new request is taken only after the last word of the previous one is emitted,
//   and an output stall holds the emit and bad states.
// Reset: synchronous, active high; clears the controller and output valid.
`default_nettype none

`include "kth_permutation_unrank_macros.svh"

module kth_permutation_unrank #(
  parameter int MAX_N = 9
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire kpu_pkg::in_word_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output kpu_pkg::out_word_t     out_data
);

  kpu_pkg::kpu_cmd_t cmd;
  kpu_pkg::kpu_sts_t sts;

  logic in_take;
  logic out_bad;
  logic out_digit;
  logic bad_word_ok;
  logic digit_ok;

  kpu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  kpu_datapath #(
    .MAX_N (MAX_N)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

  // Terms for the checks below
  assign in_take     = in_valid && in_ready;
  assign out_bad     = out_valid && out_data.bad_request;
  assign out_digit   = out_valid && !out_data.bad_request;
  assign bad_word_ok = out_data.last && (out_data.digit == '0);
  assign digit_ok    = (out_data.digit != '0) &&
                       (out_data.digit <= kpu_pkg::DIGIT_W'(MAX_N));

  // A flagged word is a single closing word with a zero digit
  `KPU_ASSERT_SAME(a_bad_word, out_bad, bad_word_ok, "flagged word malformed")

  // A regular digit lies in 1..MAX_N
  `KPU_ASSERT_SAME(a_digit_range, out_digit, digit_ok, "digit out of range")

  // Drop ready once a request is taken
  `KPU_ASSERT_NEXT(a_busy_after_accept, in_take, !in_ready, "ready held after accept")

endmodule

`default_nettype wire

// ===== bench/unrank_checker.sv =====
// Checker for the permutation unrank block: watches both handshake channels,
// predicts the digit words of each accepted request and compares them in order.
// Depends on kpu_pkg for the request and digit word types.
module unrank_checker #(
  parameter int MAX_N = 9
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  kpu_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  kpu_pkg::out_word_t out_data,
  output int                 mismatches,
  output int                 digits_pending,
  output int                 requests_taken,
  output int                 flagged_taken,
  output int                 digits_taken
);

  // Digit words still owed by the block, oldest first
  kpu_pkg::out_word_t digits_due[$];

  // Number of permutations of m values; saturate past the 32-bit range
  function automatic int unsigned perm_count(input int unsigned m);
    int unsigned p;
    p = 1;
    if (m > 12) return 32'hFFFF_FFFF;
    for (int unsigned i = 2; i <= m; i++) p = p * i;
    return p;
  endfunction

  // Expand one request into the digit words of its permutation
  function automatic void unrank_request(input kpu_pkg::in_word_t req);
    logic [kpu_pkg::DIGIT_W-1:0] pool [0:15];
    int unsigned left;
    int unsigned remain;
    int unsigned sel;
    int unsigned block;
    kpu_pkg::out_word_t w;
    if (req.size_n == 0 || req.size_n > MAX_N || req.rank_k == 0 ||
        req.rank_k > perm_count(req.size_n)) begin
      w.digit       = '0;
      w.last        = 1'b1;
      w.bad_request = 1'b1;
      digits_due.insert(digits_due.size(), w);
      flagged_taken++;
      return;
    end
    for (int i = 0; i < 16; i++) pool[i] = kpu_pkg::DIGIT_W'(i + 1);
    left   = req.size_n;
    remain = req.rank_k - 1;
    // pick one unused value per position, then close the gap in the pool
    while (left > 0) begin
      block  = perm_count(left - 1);
      sel    = remain / block;
      remain = remain % block;
      if (sel >= left) sel = left - 1;
      w.digit = pool[sel];
      for (int unsigned i = sel; i + 1 < left; i++) pool[i] = pool[i + 1];
      left--;
      w.last        = (left == 0);
      w.bad_request = 1'b0;
      digits_due.insert(digits_due.size(), w);
    end
  endfunction

  // Compare outgoing words first: a request never answers on its own edge
  always @(posedge clk) begin : watch
    kpu_pkg::out_word_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        digits_taken++;
        if (digits_due.size() == 0) begin
          $error("digit word %0d arrived with no request outstanding", out_data.digit);
          mismatches++;
        end else begin
          want = digits_due.pop_front();
          if (out_data.digit !== want.digit) begin
            $error("digit: expected %0d, got %0d", want.digit, out_data.digit);
            mismatches++;
          end
          if (out_data.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_data.last);
            mismatches++;
          end
          if (out_data.bad_request !== want.bad_request) begin
            $error("bad_request: expected %0b, got %0b", want.bad_request,
                   out_data.bad_request);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        requests_taken++;
        unrank_request(in_data);
      end
      digits_pending = digits_due.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the permutation unrank bench: clock, reset, request stimulus and the
// output drain, with unrank_checker beside the block for prediction.
// Depends on kpu_pkg, kth_permutation_unrank and unrank_checker.
module testbench;

  localparam int MAX_N = 9;
  localparam int SETTLE_CYCLES = 60;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  kpu_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_ready = 1'b0;
  kpu_pkg::out_word_t out_data;

  int mismatches;
  int digits_pending;
  int requests_taken;
  int flagged_taken;
  int digits_taken;

  // Idle rates of the current phase, percent per cycle
  int unsigned send_idle;
  int unsigned recv_stall;
  int unsigned idle_plan [4] = '{0, 48, 0, 9};
  int unsigned stall_plan [4] = '{0, 0, 48, 9};

  // Long output hold-off, counted by the drain process
  bit long_hold;
  bit hold_armed;
  int hold_left;

  kth_permutation_unrank #(
    .MAX_N(MAX_N)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  unrank_checker #(
    .MAX_N(MAX_N)
  ) i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .mismatches    (mismatches),
    .digits_pending(digits_pending),
    .requests_taken(requests_taken),
    .flagged_taken (flagged_taken),
    .digits_taken  (digits_taken)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Drain digit words: random stalls, or a long hold when asked
  always @(negedge clk) begin
    if (long_hold && !hold_armed) begin
      hold_armed = 1'b1;
      hold_left  = 400;
    end
    if (!long_hold) hold_armed = 1'b0;
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall);
    end
  end

  function automatic int unsigned perm_count(input int unsigned m);
    int unsigned p;
    p = 1;
    for (int unsigned i = 2; i <= m; i++) p = p * i;
    return p;
  endfunction

  // Offer one request word and hold it until taken
  task automatic send_request(input logic [kpu_pkg::SIZE_W-1:0] n,
                              input logic [kpu_pkg::RANK_W-1:0] k);
    while ($urandom_range(99) < send_idle) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = {n, k};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly legal requests, some on the rank edges or exact multiples, some random or malformed
  task automatic random_request();
    int unsigned pick;
    int unsigned n;
    int unsigned k;
    pick = $urandom_range(99);
    n    = $urandom_range(MAX_N, 1);
    k    = $urandom_range(perm_count(n), 1);
    if (pick < 10) begin
      k = (pick < 5) ? 1 : perm_count(n);
    end else if (pick < 20) begin
      k = $urandom_range(n, 1) * perm_count(n - 1);
    end else if (pick < 27) begin
      n = $urandom_range(15);
      k = $urandom_range(19'h7FFFF);
    end else if (pick < 31) begin
      k = 0;
    end else if (pick < 36) begin
      k = perm_count(n) + $urandom_range(19'h7FFFF - perm_count(n), 1);
    end
    send_request(n[kpu_pkg::SIZE_W-1:0], k[kpu_pkg::RANK_W-1:0]);
  endtask

  // Drop valid and wait until every owed digit word is out
  task automatic settle();
    in_valid = 1'b0;
    wait (digits_pending == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    send_idle  = 0;
    recv_stall = 0;
    long_hold  = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: size and rank extremes, exact multiples, malformed requests
    send_request(4'd1, 19'd1);
    send_request(4'd1, 19'd2);
    send_request(4'd0, 19'd1);
    send_request(4'd0, 19'd0);
    send_request(4'd3, 19'd0);
    send_request(4'd3, 19'd6);
    send_request(4'd3, 19'd7);
    send_request(4'd2, 19'd1);
    send_request(4'd2, 19'd2);
    send_request(4'd4, 19'd6);
    send_request(4'd4, 19'd12);
    send_request(4'd5, 19'd24);
    send_request(4'd8, 19'd20160);
    send_request(4'd8, 19'd40320);
    send_request(4'd9, 19'd1);
    send_request(4'd9, 19'd362880);
    send_request(4'd9, 19'd362881);
    send_request(4'd9, 19'h7FFFF);
    send_request(4'd10, 19'd1);
    send_request(4'd12, 19'd5);
    send_request(4'd15, 19'h7FFFF);
    settle();

    // random phases under different idle mixes
    for (int p = 0; p < 4; p++) begin
      send_idle  = idle_plan[p];
      recv_stall = stall_plan[p];
      repeat (72) random_request();
      settle();
      if (p == 1) begin
        // hold the output while requests keep coming, so the input backs up
        send_idle  = 0;
        recv_stall = 0;
        long_hold  = 1'b1;
        repeat (8) random_request();
        long_hold = 1'b0;
        settle();
      end
    end

    $display("Ran %0d requests (%0d flagged) yielding %0d digit words,", requests_taken,
             flagged_taken, digits_taken);
    $display("across idle, sender-gap, receiver-stall, mixed and long-hold phases.");
    if (mismatches == 0 && digits_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Hard stop if the handshakes hang
  initial begin
    #1000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/kpu_pkg.sv
design/kpu_datapath.sv
design/kpu_ctrl.sv
design/kth_permutation_unrank.sv
bench/unrank_checker.sv
bench/testbench.sv
